// File: design/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types and constants for the LRU slot directory.
// ----------------------------------------------------------------------------
`default_nettype none

package lsc_pkg;

  localparam int KEY_W = 22;
  localparam int CNT_W = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    REQ_LOOKUP  = 2'd0,
    REQ_RESERVE = 2'd1,
    REQ_PUBLISH = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_MISS      = 3'd1,
    ST_REUSED    = 3'd2,
    ST_NEW       = 3'd3,
    ST_REFUSED   = 3'd4,
    ST_NO_VICTIM = 3'd5,
    ST_PUBLISHED = 3'd6,
    ST_UNMATCHED = 3'd7
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             pub;
    logic [CNT_W-1:0] stamp;
  } slot_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic finish;
  } lsc_cmd_t;

  typedef struct packed {
    logic scan_done;
  } lsc_stat_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v == CNT_MAX) ? v : v + 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/lru_slot_cache_with_inflight.sv
// ----------------------------------------------------------------------------
// lru_slot_cache_with_inflight
// Fully associative slot directory keyed by layer and expert, with LRU
// replacement of published slots and in-flight reservations.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Contents
// --------  ---------  -------------------  ---------------------------------
// request   in         in_valid/in_ready    req_type, layer_id, expert_id,
//                                           payload_bytes
// result    out        out_valid/out_ready  status, slot_index, length_bytes,
//                                           evicted, hit/miss/eviction totals
// config    in/out     APB psel/penable     arena_enabled (0x0),
//                                           slot_limit_bytes (0x4)
//
// A request reads the occupied slots from the slot memory, one slot per cycle,
// and the scan stops at the first matching slot. Refused requests leave the
// scan state without comparing any slot.
// Reset clears counters and the fill count; slot memories are not cleared,
// slots at or above the fill count are never read as occupied.
// A result waiting in the output register holds the next commit only.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_slot_cache_with_inflight #(
  parameter int SLOTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [9:0]  layer_id,
  input  wire logic [11:0] expert_id,
  input  wire logic [31:0] payload_bytes,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [5:0]       slot_index,
  output logic [31:0]      length_bytes,
  output logic             evicted,
  output logic [31:0]      hit_total,
  output logic [31:0]      miss_total,
  output logic [31:0]      eviction_total
);

  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  logic               arena_enabled;
  logic [31:0]        slot_limit_bytes;
  logic               cfg_we;
  lsc_pkg::lsc_cmd_t  cmd;
  lsc_pkg::lsc_stat_t stat;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      arena_enabled    <= 1'b0;
      slot_limit_bytes <= '0;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_ENABLE: arena_enabled    <= pwdata[0];
        REG_LIMIT:  slot_limit_bytes <= pwdata;
        default:    arena_enabled    <= arena_enabled;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ENABLE: prdata = {31'b0, arena_enabled};
      REG_LIMIT:  prdata = slot_limit_bytes;
      default:    prdata = '0;
    endcase
  end

  lsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  lsc_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .req_type         (req_type),
    .layer_id         (layer_id),
    .expert_id        (expert_id),
    .payload_bytes    (payload_bytes),
    .arena_enabled    (arena_enabled),
    .slot_limit_bytes (slot_limit_bytes),
    .status           (status),
    .slot_index       (slot_index),
    .length_bytes     (length_bytes),
    .evicted          (evicted),
    .hit_total        (hit_total),
    .miss_total       (miss_total),
    .eviction_total   (eviction_total)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result produced without a request in progress");

  a_evict_on_new: assert property (@(posedge clk) disable iff (rst)
    (out_valid && evicted) |-> (status == lsc_pkg::ST_NEW))
    else $error("eviction flagged on a result that granted no slot");

  a_no_index_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == lsc_pkg::ST_MISS || status == lsc_pkg::ST_REFUSED ||
                   status == lsc_pkg::ST_NO_VICTIM || status == lsc_pkg::ST_UNMATCHED))
    |-> (slot_index == 6'd0))
    else $error("slot index set on a result without a slot");

endmodule

`default_nettype wire

// File: design/lsc_dp.sv
// ----------------------------------------------------------------------------
// lsc_dp
// Slot memories, request registers, scan compare, victim search and counters.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_dp #(
  parameter int SLOTS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lsc_pkg::lsc_cmd_t   cmd,
  output lsc_pkg::lsc_stat_t       stat,
  input  wire logic [1:0]          req_type,
  input  wire logic [9:0]          layer_id,
  input  wire logic [11:0]         expert_id,
  input  wire logic [31:0]         payload_bytes,
  input  wire logic                arena_enabled,
  input  wire logic [31:0]         slot_limit_bytes,
  output logic [2:0]               status,
  output logic [5:0]               slot_index,
  output logic [31:0]              length_bytes,
  output logic                     evicted,
  output logic [31:0]              hit_total,
  output logic [31:0]              miss_total,
  output logic [31:0]              eviction_total
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  lsc_pkg::slot_t tag_mem [SLOTS];
  logic [31:0]    len_mem [SLOTS];

  lsc_pkg::req_t               req_q;
  logic [lsc_pkg::KEY_W-1:0]   key_q;
  logic [31:0]                 bytes_q;

  logic [CW-1:0]  fill;
  logic [31:0]    use_clock;
  logic [31:0]    hits_count;
  logic [31:0]    misses_count;
  logic [31:0]    evictions_count;

  logic [CW-1:0]  rd_cnt;
  logic           q_valid;
  logic [IW-1:0]  q_idx;
  lsc_pkg::slot_t tag_q;
  logic [31:0]    len_q;

  logic           found;
  logic [IW-1:0]  found_idx;
  lsc_pkg::slot_t found_tag;
  logic [31:0]    found_len;
  logic           have_old;
  logic [31:0]    oldest;
  logic [IW-1:0]  old_idx;

  logic           skip;
  logic           issued_all;
  logic           hit_now;
  logic           victim_take;

  lsc_pkg::status_t res_status;
  logic [IW-1:0]  res_idx;
  logic [IW+5:0]  res_idx_wide;
  logic [31:0]    res_len;
  logic           res_ev;
  logic           tag_we;
  logic           len_we;
  logic [IW-1:0]  wr_idx;
  lsc_pkg::slot_t wr_tag;
  logic [31:0]    stamp_new;
  logic [CW-1:0]  fill_next;
  logic [31:0]    use_clock_next;
  logic [31:0]    hits_count_next;
  logic [31:0]    misses_count_next;
  logic [31:0]    evictions_count_next;

  always_comb begin
    unique case (req_q)
      lsc_pkg::REQ_LOOKUP:  skip = !arena_enabled;
      lsc_pkg::REQ_RESERVE: skip = !arena_enabled || (bytes_q > slot_limit_bytes);
      lsc_pkg::REQ_PUBLISH: skip = 1'b0;
      default:              skip = 1'b1;
    endcase
  end

  assign issued_all = (rd_cnt == fill);
  assign hit_now = q_valid && (tag_q.key == key_q) &&
                   ((req_q == lsc_pkg::REQ_PUBLISH) ? !tag_q.pub : tag_q.pub);
  assign victim_take = q_valid && tag_q.pub && (!have_old || (tag_q.stamp < oldest));
  assign stat.scan_done = skip || hit_now || (issued_all && !q_valid);

  always_comb begin
    stamp_new            = lsc_pkg::sat_inc(use_clock);
    res_status           = lsc_pkg::ST_REFUSED;
    res_idx              = '0;
    res_len              = '0;
    res_ev               = 1'b0;
    tag_we               = 1'b0;
    len_we               = 1'b0;
    wr_idx               = found_idx;
    wr_tag               = found_tag;
    fill_next            = fill;
    use_clock_next       = use_clock;
    hits_count_next      = hits_count;
    misses_count_next    = misses_count;
    evictions_count_next = evictions_count;
    unique case (req_q)
      lsc_pkg::REQ_LOOKUP: begin
        if (!skip) begin
          if (found) begin
            res_status      = lsc_pkg::ST_HIT;
            res_idx         = found_idx;
            res_len         = found_len;
            tag_we          = 1'b1;
            wr_tag.stamp    = stamp_new;
            use_clock_next  = stamp_new;
            hits_count_next = lsc_pkg::sat_inc(hits_count);
          end else begin
            res_status        = lsc_pkg::ST_MISS;
            misses_count_next = lsc_pkg::sat_inc(misses_count);
          end
        end
      end
      lsc_pkg::REQ_RESERVE: begin
        res_len = bytes_q;
        if (!skip) begin
          if (found) begin
            res_status     = lsc_pkg::ST_REUSED;
            res_idx        = found_idx;
            tag_we         = 1'b1;
            wr_tag.stamp   = stamp_new;
            use_clock_next = stamp_new;
          end else if (fill < CW'(SLOTS)) begin
            res_status     = lsc_pkg::ST_NEW;
            res_idx        = fill[IW-1:0];
            wr_idx         = fill[IW-1:0];
            wr_tag         = '{key: key_q, pub: 1'b0, stamp: stamp_new};
            tag_we         = 1'b1;
            len_we         = 1'b1;
            fill_next      = fill + 1'b1;
            use_clock_next = stamp_new;
          end else if (have_old) begin
            res_status           = lsc_pkg::ST_NEW;
            res_idx              = old_idx;
            res_ev               = 1'b1;
            wr_idx               = old_idx;
            wr_tag               = '{key: key_q, pub: 1'b0, stamp: stamp_new};
            tag_we               = 1'b1;
            len_we               = 1'b1;
            use_clock_next       = stamp_new;
            evictions_count_next = lsc_pkg::sat_inc(evictions_count);
          end else begin
            res_status = lsc_pkg::ST_NO_VICTIM;
          end
        end
      end
      lsc_pkg::REQ_PUBLISH: begin
        if (found) begin
          res_status = lsc_pkg::ST_PUBLISHED;
          res_idx    = found_idx;
          tag_we     = 1'b1;
          wr_tag.pub = 1'b1;
        end else begin
          res_status = lsc_pkg::ST_UNMATCHED;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_idx_wide = {6'b0, res_idx};

  always_ff @(posedge clk) begin
    tag_q <= tag_mem[rd_cnt[IW-1:0]];
    len_q <= len_mem[rd_cnt[IW-1:0]];
    q_idx <= rd_cnt[IW-1:0];
    if (cmd.finish && tag_we) begin
      tag_mem[wr_idx] <= wr_tag;
    end
    if (cmd.finish && len_we) begin
      len_mem[wr_idx] <= bytes_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_q   <= lsc_pkg::req_t'(req_type);
      key_q   <= {layer_id, expert_id};
      bytes_q <= payload_bytes;
    end
    if (cmd.scan && hit_now) begin
      found_idx <= q_idx;
      found_tag <= tag_q;
      found_len <= len_q;
    end
    if (cmd.scan && victim_take) begin
      oldest  <= tag_q.stamp;
      old_idx <= q_idx;
    end
    if (cmd.finish) begin
      status       <= res_status;
      slot_index   <= res_idx_wide[5:0];
      length_bytes <= res_len;
      evicted      <= res_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt          <= '0;
      q_valid         <= 1'b0;
      found           <= 1'b0;
      have_old        <= 1'b0;
      fill            <= '0;
      use_clock       <= '0;
      hits_count      <= '0;
      misses_count    <= '0;
      evictions_count <= '0;
    end else begin
      if (cmd.start) begin
        rd_cnt   <= '0;
        q_valid  <= 1'b0;
        found    <= 1'b0;
        have_old <= 1'b0;
      end else if (cmd.scan) begin
        q_valid <= !issued_all;
        if (!issued_all) begin
          rd_cnt <= rd_cnt + 1'b1;
        end
        if (hit_now) begin
          found <= 1'b1;
        end
        if (victim_take) begin
          have_old <= 1'b1;
        end
      end
      if (cmd.finish) begin
        fill            <= fill_next;
        use_clock       <= use_clock_next;
        hits_count      <= hits_count_next;
        misses_count    <= misses_count_next;
        evictions_count <= evictions_count_next;
      end
    end
  end

  assign hit_total      = hits_count;
  assign miss_total     = misses_count;
  assign eviction_total = evictions_count;

endmodule

`default_nettype wire

// File: design/lsc_ctrl.sv
// ----------------------------------------------------------------------------
// lsc_ctrl
// Request sequencer: accept, scan the occupied slots, commit and hand over.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output lsc_pkg::lsc_cmd_t       cmd,
  input  wire lsc_pkg::lsc_stat_t stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;

  assign cmd.start  = in_valid && in_ready;
  assign cmd.scan   = (state == S_SCAN);
  assign cmd.finish = (state == S_FINISH) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.start) begin
            state    <= S_SCAN;
            in_ready <= 1'b0;
          end else begin
            in_ready <= 1'b1;
          end
        end
        S_SCAN: begin
          if (stat.scan_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (cmd.finish) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_ready <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
